### rtl/lcc_pkg.sv
package lcc_pkg;

  localparam int COORD_W    = 7;
  localparam int SYM_W      = 8;
  localparam int PLACE_W    = 8;
  localparam int POFS_W     = 10;
  localparam int GSUM_W     = 21;
  localparam int GCNT_W     = 15;
  localparam int PSUM_W     = 20;
  localparam int PCNT_W     = 11;
  localparam int PCEN_W     = 9;
  localparam int SQ_W       = 17;
  localparam int DIST_W     = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ENEMY_LABEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_LABEL   = 1'd1;

  // func on input and kind on output share the same coding
  localparam logic KIND_GRID  = 1'b0;
  localparam logic KIND_PIECE = 1'b1;

  localparam logic [SYM_W-1:0] MARK_SYMBOL     = 8'h2A;
  localparam logic [SYM_W-1:0] ENEMY_LABEL_RST = 8'd88;
  localparam logic [SYM_W-1:0] OWN_LABEL_RST   = 8'd79;

  localparam logic [COORD_W-1:0] GCEN_MAX = 7'd127;
  localparam logic [PCEN_W-1:0]  PCEN_MAX = 9'd254;
  localparam logic [PCEN_W-1:0]  PCEN_MIN = 9'h180;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam int DIV_STEPS = GSUM_W;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic              kind;
    logic [GSUM_W-1:0] e_rsum;
    logic [GSUM_W-1:0] e_csum;
    logic [GCNT_W-1:0] e_cnt;
    logic [GSUM_W-1:0] o_rsum;
    logic [GSUM_W-1:0] o_csum;
    logic [GCNT_W-1:0] o_cnt;
    logic [PSUM_W-1:0] p_rsum;
    logic [PSUM_W-1:0] p_csum;
    logic [PCNT_W-1:0] p_cnt;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [GSUM_W-1:0] dividend;
    logic [GCNT_W-1:0] divisor;
  } div_req_t;

endpackage

### rtl/lcc_front.sv
module lcc_front #(
  parameter int GRID_ROWS  = 128,
  parameter int GRID_COLS  = 128,
  parameter int PIECE_ROWS = 32,
  parameter int PIECE_COLS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [lcc_pkg::COORD_W-1:0]      in_row,
  input  logic [lcc_pkg::COORD_W-1:0]      in_col,
  input  logic [lcc_pkg::SYM_W-1:0]        in_cell_symbol,
  input  logic signed [lcc_pkg::PLACE_W-1:0] in_place_row,
  input  logic signed [lcc_pkg::PLACE_W-1:0] in_place_col,
  input  logic                             in_last,
  input  logic                             q_full,
  output logic                             q_push,
  output lcc_pkg::job_t                    q_job
);

  logic [lcc_pkg::SYM_W-1:0]  enemy_label_r, own_label_r;
  logic [lcc_pkg::GSUM_W-1:0] e_rsum_r, e_csum_r, o_rsum_r, o_csum_r;
  logic [lcc_pkg::GCNT_W-1:0] e_cnt_r, o_cnt_r;
  logic [lcc_pkg::PSUM_W-1:0] p_rsum_r, p_csum_r;
  logic [lcc_pkg::PCNT_W-1:0] p_cnt_r;

  logic [lcc_pkg::GSUM_W-1:0] e_rsum_nxt, e_csum_nxt, o_rsum_nxt, o_csum_nxt;
  logic [lcc_pkg::GCNT_W-1:0] e_cnt_nxt, o_cnt_nxt;
  logic [lcc_pkg::PSUM_W-1:0] p_rsum_nxt, p_csum_nxt;
  logic [lcc_pkg::PCNT_W-1:0] p_cnt_nxt;

  logic [lcc_pkg::GSUM_W-1:0] e_rsum_upd, e_csum_upd, o_rsum_upd, o_csum_upd;
  logic [lcc_pkg::GCNT_W-1:0] e_cnt_upd, o_cnt_upd;
  logic [lcc_pkg::PSUM_W-1:0] p_rsum_upd, p_csum_upd;
  logic [lcc_pkg::PCNT_W-1:0] p_cnt_upd;

  logic                       acc, grid_cell, piece_cell, grid_in, piece_in;
  logic                       e_hit, o_hit, p_hit;
  logic [lcc_pkg::POFS_W-1:0] p_row_pos, p_col_pos;

  function automatic logic [lcc_pkg::GSUM_W-1:0] gsum_add(
    input logic [lcc_pkg::GSUM_W-1:0]  s,
    input logic [lcc_pkg::COORD_W-1:0] v
  );
    logic [lcc_pkg::GSUM_W:0] t;
    t = {1'b0, s} + (lcc_pkg::GSUM_W + 1)'(v);
    return t[lcc_pkg::GSUM_W] ? {lcc_pkg::GSUM_W{1'b1}} : t[lcc_pkg::GSUM_W-1:0];
  endfunction

  function automatic logic [lcc_pkg::PSUM_W-1:0] psum_add(
    input logic [lcc_pkg::PSUM_W-1:0] s,
    input logic [lcc_pkg::POFS_W-1:0] v
  );
    logic [lcc_pkg::PSUM_W:0] t;
    t = {s[lcc_pkg::PSUM_W-1], s}
      + {{(lcc_pkg::PSUM_W + 1 - lcc_pkg::POFS_W){v[lcc_pkg::POFS_W-1]}}, v};
    if (t[lcc_pkg::PSUM_W] != t[lcc_pkg::PSUM_W-1]) begin
      return t[lcc_pkg::PSUM_W] ? {1'b1, {(lcc_pkg::PSUM_W-1){1'b0}}}
                                : {1'b0, {(lcc_pkg::PSUM_W-1){1'b1}}};
    end
    return t[lcc_pkg::PSUM_W-1:0];
  endfunction

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;

  always_comb begin
    grid_cell  = acc && (in_func == lcc_pkg::KIND_GRID);
    piece_cell = acc && (in_func == lcc_pkg::KIND_PIECE);
    grid_in    = (int'(in_row) < GRID_ROWS) && (int'(in_col) < GRID_COLS);
    piece_in   = (int'(in_row) < PIECE_ROWS) && (int'(in_col) < PIECE_COLS);
    e_hit      = grid_cell && grid_in && (in_cell_symbol == enemy_label_r);
    o_hit      = grid_cell && grid_in && (in_cell_symbol == own_label_r);
    p_hit      = piece_cell && piece_in && (in_cell_symbol == lcc_pkg::MARK_SYMBOL);
    // grid position of a piece cell: sign-extended offset plus local position
    p_row_pos  = {{2{in_place_row[7]}}, in_place_row} + {3'b000, in_row};
    p_col_pos  = {{2{in_place_col[7]}}, in_place_col} + {3'b000, in_col};

    e_rsum_upd = e_hit ? gsum_add(e_rsum_r, in_row) : e_rsum_r;
    e_csum_upd = e_hit ? gsum_add(e_csum_r, in_col) : e_csum_r;
    e_cnt_upd  = (e_hit && !(&e_cnt_r)) ? e_cnt_r + lcc_pkg::GCNT_W'(1) : e_cnt_r;
    o_rsum_upd = o_hit ? gsum_add(o_rsum_r, in_row) : o_rsum_r;
    o_csum_upd = o_hit ? gsum_add(o_csum_r, in_col) : o_csum_r;
    o_cnt_upd  = (o_hit && !(&o_cnt_r)) ? o_cnt_r + lcc_pkg::GCNT_W'(1) : o_cnt_r;
    p_rsum_upd = p_hit ? psum_add(p_rsum_r, p_row_pos) : p_rsum_r;
    p_csum_upd = p_hit ? psum_add(p_csum_r, p_col_pos) : p_csum_r;
    p_cnt_upd  = (p_hit && !(&p_cnt_r)) ? p_cnt_r + lcc_pkg::PCNT_W'(1) : p_cnt_r;

    e_rsum_nxt = e_rsum_upd;
    e_csum_nxt = e_csum_upd;
    e_cnt_nxt  = e_cnt_upd;
    o_rsum_nxt = o_rsum_upd;
    o_csum_nxt = o_csum_upd;
    o_cnt_nxt  = o_cnt_upd;
    p_rsum_nxt = p_rsum_upd;
    p_csum_nxt = p_csum_upd;
    p_cnt_nxt  = p_cnt_upd;
    if (grid_cell && in_last) begin
      e_rsum_nxt = '0;
      e_csum_nxt = '0;
      e_cnt_nxt  = '0;
      o_rsum_nxt = '0;
      o_csum_nxt = '0;
      o_cnt_nxt  = '0;
    end
    if (piece_cell && in_last) begin
      p_rsum_nxt = '0;
      p_csum_nxt = '0;
      p_cnt_nxt  = '0;
    end

    q_push       = acc && in_last;
    q_job.kind   = in_func;
    q_job.e_rsum = e_rsum_upd;
    q_job.e_csum = e_csum_upd;
    q_job.e_cnt  = e_cnt_upd;
    q_job.o_rsum = o_rsum_upd;
    q_job.o_csum = o_csum_upd;
    q_job.o_cnt  = o_cnt_upd;
    q_job.p_rsum = p_rsum_upd;
    q_job.p_csum = p_csum_upd;
    q_job.p_cnt  = p_cnt_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enemy_label_r <= lcc_pkg::ENEMY_LABEL_RST;
      own_label_r   <= lcc_pkg::OWN_LABEL_RST;
      e_rsum_r      <= '0;
      e_csum_r      <= '0;
      e_cnt_r       <= '0;
      o_rsum_r      <= '0;
      o_csum_r      <= '0;
      o_cnt_r       <= '0;
      p_rsum_r      <= '0;
      p_csum_r      <= '0;
      p_cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lcc_pkg::REG_ENEMY_LABEL: enemy_label_r <= cfg_data;
          lcc_pkg::REG_OWN_LABEL:   own_label_r   <= cfg_data;
          default: ;
        endcase
      end
      e_rsum_r <= e_rsum_nxt;
      e_csum_r <= e_csum_nxt;
      e_cnt_r  <= e_cnt_nxt;
      o_rsum_r <= o_rsum_nxt;
      o_csum_r <= o_csum_nxt;
      o_cnt_r  <= o_cnt_nxt;
      p_rsum_r <= p_rsum_nxt;
      p_csum_r <= p_csum_nxt;
      p_cnt_r  <= p_cnt_nxt;
    end
  end

  a_grid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (grid_cell && in_last) |=> (e_cnt_r == '0 && o_cnt_r == '0 && e_rsum_r == '0))
    else $error("grid accumulators not cleared after last grid cell");

endmodule

### rtl/lcc_queue.sv
module lcc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lcc_pkg::job_t push_job,
  input  logic          pop,
  output lcc_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);

  lcc_pkg::job_t                entries_r [lcc_pkg::QDEPTH];
  logic [lcc_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [lcc_pkg::QCNT_W-1:0]   count_r;
  logic [lcc_pkg::QPTR_W-1:0]   wr_ptr_nxt, rd_ptr_nxt;
  logic [lcc_pkg::QCNT_W-1:0]   count_nxt;

  assign full     = (count_r == lcc_pkg::QCNT_W'(lcc_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign head_job = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("job queue overflow");

endmodule

### rtl/lcc_div.sv
module lcc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lcc_pkg::div_req_t          req,
  output logic                       done,
  output logic [lcc_pkg::GSUM_W-1:0] quotient
);

  logic                          busy_r, done_r;
  logic [lcc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [lcc_pkg::GCNT_W-1:0]    rem_r, dvsr_r;
  logic [lcc_pkg::GSUM_W-1:0]    quo_r;

  logic                          busy_nxt, done_nxt;
  logic [lcc_pkg::DIV_CNT_W-1:0] cnt_nxt;
  logic [lcc_pkg::GCNT_W-1:0]    rem_nxt, dvsr_nxt;
  logic [lcc_pkg::GSUM_W-1:0]    quo_nxt;

  logic [lcc_pkg::GCNT_W:0]      trial, diff;
  logic                          qbit;

  assign done     = done_r;
  assign quotient = quo_r;

  // restoring radix-2, one quotient bit per cycle; dividend shifts out of quo_r
  always_comb begin
    trial    = {rem_r, quo_r[lcc_pkg::GSUM_W-1]};
    diff     = trial - {1'b0, dvsr_r};
    qbit     = (trial >= {1'b0, dvsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = lcc_pkg::DIV_CNT_W'(lcc_pkg::DIV_STEPS - 1);
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[lcc_pkg::GCNT_W-1:0] : trial[lcc_pkg::GCNT_W-1:0];
      quo_nxt = {quo_r[lcc_pkg::GSUM_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    quo_r  <= quo_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

endmodule

### rtl/lcc_back.sv
module lcc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  lcc_pkg::job_t                     q_job,
  output logic                              q_pop,
  output lcc_pkg::div_req_t                 div_req,
  input  logic                              div_done,
  input  logic [lcc_pkg::GSUM_W-1:0]        div_quo,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [lcc_pkg::COORD_W-1:0]       out_enemy_row_centre,
  output logic [lcc_pkg::COORD_W-1:0]       out_enemy_col_centre,
  output logic [lcc_pkg::COORD_W-1:0]       out_own_row_centre,
  output logic [lcc_pkg::COORD_W-1:0]       out_own_col_centre,
  output logic signed [lcc_pkg::PCEN_W-1:0] out_piece_row_centre,
  output logic signed [lcc_pkg::PCEN_W-1:0] out_piece_col_centre,
  output logic [lcc_pkg::DIST_W-1:0]        out_dist_own,
  output logic [lcc_pkg::DIST_W-1:0]        out_dist_enemy,
  output logic                              out_enemy_present,
  output logic                              out_own_present,
  output logic                              out_piece_present
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DIV_START = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
  localparam logic [2:0] ST_SQ        = 3'd3;
  localparam logic [2:0] ST_OUT       = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  lcc_pkg::job_t               job_r, job_nxt;
  logic [1:0]                  k_r, k_nxt;
  logic [lcc_pkg::COORD_W-1:0] e_row_r, e_col_r, o_row_r, o_col_r;
  logic [lcc_pkg::COORD_W-1:0] e_row_nxt, e_col_nxt, o_row_nxt, o_col_nxt;
  logic                        e_pres_r, o_pres_r, e_pres_nxt, o_pres_nxt;
  logic [lcc_pkg::PCEN_W-1:0]  p_row_r, p_col_r, p_row_nxt, p_col_nxt;
  logic                        p_pres_r, p_pres_nxt;
  logic [lcc_pkg::SQ_W-1:0]    sq_or_r, sq_oc_r, sq_er_r, sq_ec_r;
  logic [lcc_pkg::SQ_W-1:0]    sq_or_nxt, sq_oc_nxt, sq_er_nxt, sq_ec_nxt;

  logic                        ov_r, ov_nxt;
  logic                        okind_r, okind_nxt;
  logic [lcc_pkg::COORD_W-1:0] oer_r, oec_r, oor_r, ooc_r;
  logic [lcc_pkg::COORD_W-1:0] oer_nxt, oec_nxt, oor_nxt, ooc_nxt;
  logic [lcc_pkg::PCEN_W-1:0]  opr_r, opc_r, opr_nxt, opc_nxt;
  logic [lcc_pkg::DIST_W-1:0]  odo_r, ode_r, odo_nxt, ode_nxt;
  logic                        oep_r, oop_r, opp_r, oep_nxt, oop_nxt, opp_nxt;

  logic [lcc_pkg::GSUM_W-1:0]  sel_sum;
  logic [lcc_pkg::GCNT_W-1:0]  sel_cnt;
  logic                        sel_neg, cnt_zero;
  logic [lcc_pkg::GSUM_W-1:0]  p_rext, p_cext, p_rmag, p_cmag;
  logic [lcc_pkg::COORD_W-1:0] gval;
  logic [lcc_pkg::PCEN_W-1:0]  pval;
  logic signed [9:0]           dr_o, dc_o, dr_e, dc_e;
  logic signed [19:0]          m_or, m_oc, m_er, m_ec;
  logic                        last_div;

  always_comb begin
    p_rext = {job_r.p_rsum[lcc_pkg::PSUM_W-1], job_r.p_rsum};
    p_cext = {job_r.p_csum[lcc_pkg::PSUM_W-1], job_r.p_csum};
    p_rmag = job_r.p_rsum[lcc_pkg::PSUM_W-1] ? (~p_rext + 1'b1) : p_rext;
    p_cmag = job_r.p_csum[lcc_pkg::PSUM_W-1] ? (~p_cext + 1'b1) : p_cext;

    sel_neg = 1'b0;
    if (job_r.kind == lcc_pkg::KIND_GRID) begin
      case (k_r)
        2'd0:    begin sel_sum = job_r.e_rsum; sel_cnt = job_r.e_cnt; end
        2'd1:    begin sel_sum = job_r.e_csum; sel_cnt = job_r.e_cnt; end
        2'd2:    begin sel_sum = job_r.o_rsum; sel_cnt = job_r.o_cnt; end
        default: begin sel_sum = job_r.o_csum; sel_cnt = job_r.o_cnt; end
      endcase
    end else if (k_r == 2'd0) begin
      sel_sum = p_rmag;
      sel_cnt = lcc_pkg::GCNT_W'(job_r.p_cnt);
      sel_neg = job_r.p_rsum[lcc_pkg::PSUM_W-1];
    end else begin
      sel_sum = p_cmag;
      sel_cnt = lcc_pkg::GCNT_W'(job_r.p_cnt);
      sel_neg = job_r.p_csum[lcc_pkg::PSUM_W-1];
    end
    cnt_zero = (sel_cnt == '0);

    // clamp the quotient: grid 0..127, piece -128..254
    if (cnt_zero) begin
      gval = '0;
    end else if (div_quo > lcc_pkg::GSUM_W'(lcc_pkg::GCEN_MAX)) begin
      gval = lcc_pkg::GCEN_MAX;
    end else begin
      gval = div_quo[lcc_pkg::COORD_W-1:0];
    end
    if (cnt_zero) begin
      pval = '0;
    end else if (sel_neg) begin
      pval = (div_quo > lcc_pkg::GSUM_W'(128)) ? lcc_pkg::PCEN_MIN
                                              : (~div_quo[lcc_pkg::PCEN_W-1:0] + 1'b1);
    end else begin
      pval = (div_quo > lcc_pkg::GSUM_W'(lcc_pkg::PCEN_MAX)) ? lcc_pkg::PCEN_MAX
                                                             : div_quo[lcc_pkg::PCEN_W-1:0];
    end

    last_div = (job_r.kind == lcc_pkg::KIND_GRID) ? (k_r == 2'd3) : (k_r == 2'd1);

    dr_o = $signed({p_row_r[lcc_pkg::PCEN_W-1], p_row_r}) - $signed({3'b000, o_row_r});
    dc_o = $signed({p_col_r[lcc_pkg::PCEN_W-1], p_col_r}) - $signed({3'b000, o_col_r});
    dr_e = $signed({p_row_r[lcc_pkg::PCEN_W-1], p_row_r}) - $signed({3'b000, e_row_r});
    dc_e = $signed({p_col_r[lcc_pkg::PCEN_W-1], p_col_r}) - $signed({3'b000, e_col_r});
    m_or = dr_o * dr_o;
    m_oc = dc_o * dc_o;
    m_er = dr_e * dr_e;
    m_ec = dc_e * dc_e;

    div_req.start    = (state_r == ST_DIV_START);
    div_req.dividend = sel_sum;
    div_req.divisor  = sel_cnt;

    state_nxt  = state_r;
    job_nxt    = job_r;
    k_nxt      = k_r;
    e_row_nxt  = e_row_r;
    e_col_nxt  = e_col_r;
    o_row_nxt  = o_row_r;
    o_col_nxt  = o_col_r;
    e_pres_nxt = e_pres_r;
    o_pres_nxt = o_pres_r;
    p_row_nxt  = p_row_r;
    p_col_nxt  = p_col_r;
    p_pres_nxt = p_pres_r;
    sq_or_nxt  = sq_or_r;
    sq_oc_nxt  = sq_oc_r;
    sq_er_nxt  = sq_er_r;
    sq_ec_nxt  = sq_ec_r;
    ov_nxt     = (ov_r && out_ready) ? 1'b0 : ov_r;
    okind_nxt  = okind_r;
    oer_nxt    = oer_r;
    oec_nxt    = oec_r;
    oor_nxt    = oor_r;
    ooc_nxt    = ooc_r;
    opr_nxt    = opr_r;
    opc_nxt    = opc_r;
    odo_nxt    = odo_r;
    ode_nxt    = ode_r;
    oep_nxt    = oep_r;
    oop_nxt    = oop_r;
    opp_nxt    = opp_r;
    q_pop      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          k_nxt     = 2'd0;
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (job_r.kind == lcc_pkg::KIND_GRID) begin
            case (k_r)
              2'd0: begin
                e_row_nxt  = gval;
                e_pres_nxt = !cnt_zero;
                if (cnt_zero) begin
                  e_col_nxt = '0;
                end
              end
              2'd1: e_col_nxt = gval;
              2'd2: begin
                o_row_nxt  = gval;
                o_pres_nxt = !cnt_zero;
                if (cnt_zero) begin
                  o_col_nxt = '0;
                end
              end
              default: o_col_nxt = gval;
            endcase
          end else if (k_r == 2'd0) begin
            p_row_nxt  = pval;
            p_pres_nxt = !cnt_zero;
          end else begin
            p_col_nxt = pval;
          end
          k_nxt = k_r + 1'b1;
          if (!last_div) begin
            state_nxt = ST_DIV_START;
          end else if (job_r.kind == lcc_pkg::KIND_GRID) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        sq_or_nxt = m_or[lcc_pkg::SQ_W-1:0];
        sq_oc_nxt = m_oc[lcc_pkg::SQ_W-1:0];
        sq_er_nxt = m_er[lcc_pkg::SQ_W-1:0];
        sq_ec_nxt = m_ec[lcc_pkg::SQ_W-1:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          okind_nxt = job_r.kind;
          oer_nxt   = e_row_r;
          oec_nxt   = e_col_r;
          oor_nxt   = o_row_r;
          ooc_nxt   = o_col_r;
          oep_nxt   = e_pres_r;
          oop_nxt   = o_pres_r;
          if (job_r.kind == lcc_pkg::KIND_GRID) begin
            opr_nxt = '0;
            opc_nxt = '0;
            odo_nxt = '0;
            ode_nxt = '0;
            opp_nxt = 1'b0;
          end else begin
            opr_nxt = p_row_r;
            opc_nxt = p_col_r;
            odo_nxt = lcc_pkg::DIST_W'(sq_or_r) + lcc_pkg::DIST_W'(sq_oc_r);
            ode_nxt = lcc_pkg::DIST_W'(sq_er_r) + lcc_pkg::DIST_W'(sq_ec_r);
            opp_nxt = p_pres_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ov_r     <= 1'b0;
      e_row_r  <= '0;
      e_col_r  <= '0;
      o_row_r  <= '0;
      o_col_r  <= '0;
      e_pres_r <= 1'b0;
      o_pres_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      e_row_r  <= e_row_nxt;
      e_col_r  <= e_col_nxt;
      o_row_r  <= o_row_nxt;
      o_col_r  <= o_col_nxt;
      e_pres_r <= e_pres_nxt;
      o_pres_r <= o_pres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    k_r      <= k_nxt;
    p_row_r  <= p_row_nxt;
    p_col_r  <= p_col_nxt;
    p_pres_r <= p_pres_nxt;
    sq_or_r  <= sq_or_nxt;
    sq_oc_r  <= sq_oc_nxt;
    sq_er_r  <= sq_er_nxt;
    sq_ec_r  <= sq_ec_nxt;
    okind_r  <= okind_nxt;
    oer_r    <= oer_nxt;
    oec_r    <= oec_nxt;
    oor_r    <= oor_nxt;
    ooc_r    <= ooc_nxt;
    opr_r    <= opr_nxt;
    opc_r    <= opc_nxt;
    odo_r    <= odo_nxt;
    ode_r    <= ode_nxt;
    oep_r    <= oep_nxt;
    oop_r    <= oop_nxt;
    opp_r    <= opp_nxt;
  end

  assign out_valid            = ov_r;
  assign out_kind             = okind_r;
  assign out_enemy_row_centre = oer_r;
  assign out_enemy_col_centre = oec_r;
  assign out_own_row_centre   = oor_r;
  assign out_own_col_centre   = ooc_r;
  assign out_piece_row_centre = $signed(opr_r);
  assign out_piece_col_centre = $signed(opc_r);
  assign out_dist_own         = odo_r;
  assign out_dist_enemy       = ode_r;
  assign out_enemy_present    = oep_r;
  assign out_own_present      = oop_r;
  assign out_piece_present    = opp_r;

  a_grid_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == lcc_pkg::KIND_GRID)
      |-> (odo_r == '0 && ode_r == '0 && !opp_r && opr_r == '0))
    else $error("grid result carries piece fields");

  a_empty_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!e_pres_r |-> (e_row_r == '0 && e_col_r == '0))
      and (!o_pres_r |-> (o_row_r == '0 && o_col_r == '0)))
    else $error("absent class has nonzero centre");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_DIV_START))
    else $error("job popped outside idle");

endmodule

### rtl/labeled_cell_centroid_distance_unit.sv
// Labeled cell centroid distance unit.
// Input channel (in_*): one cell per beat. func 0 beats are grid cells whose
// symbol is matched against the enemy and own labels; func 1 beats are piece
// cells, counted when the symbol is '*'. A beat with last set closes its scan.
// Cells are taken one per cycle; in_ready drops only while the two-entry job
// queue between the accumulators and the result engine is full.
// Output channel (out_*): one beat per closed scan, in scan order. A grid
// result gives both class centroids; a piece result gives the piece centroid
// and its squared distances to the own and enemy centroids.
// After the last cell, a grid scan runs four divisions on the shared serial
// divider (each 21 quotient steps plus start and hand-off) and a piece scan
// two divisions and one squaring step before out_valid rises. The engine
// works on one job at a time, so the serial divider sets the job rate.
// Configuration (cfg_*): index 0 enemy label, 1 own label; written while
// idle, a rule on the user that the block itself does not enforce.
// Reset (rst_n low, synchronous): labels return to 88 and 79, all sums and
// stored class centroids clear, the queue empties and out_valid drops.
// A stalled receiver holds the result in the output register; the engine can
// finish the next job meanwhile, and cells keep flowing until the queue fills.
module labeled_cell_centroid_distance_unit #(
  parameter int GRID_ROWS  = 128,
  parameter int GRID_COLS  = 128,
  parameter int PIECE_ROWS = 32,
  parameter int PIECE_COLS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [lcc_pkg::COORD_W-1:0]        in_row,
  input  logic [lcc_pkg::COORD_W-1:0]        in_col,
  input  logic [lcc_pkg::SYM_W-1:0]          in_cell_symbol,
  input  logic signed [lcc_pkg::PLACE_W-1:0] in_place_row,
  input  logic signed [lcc_pkg::PLACE_W-1:0] in_place_col,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_kind,
  output logic [lcc_pkg::COORD_W-1:0]        out_enemy_row_centre,
  output logic [lcc_pkg::COORD_W-1:0]        out_enemy_col_centre,
  output logic [lcc_pkg::COORD_W-1:0]        out_own_row_centre,
  output logic [lcc_pkg::COORD_W-1:0]        out_own_col_centre,
  output logic signed [lcc_pkg::PCEN_W-1:0]  out_piece_row_centre,
  output logic signed [lcc_pkg::PCEN_W-1:0]  out_piece_col_centre,
  output logic [lcc_pkg::DIST_W-1:0]         out_dist_own,
  output logic [lcc_pkg::DIST_W-1:0]         out_dist_enemy,
  output logic                               out_enemy_present,
  output logic                               out_own_present,
  output logic                               out_piece_present
);

  logic                       q_full, q_empty, q_push, q_pop;
  lcc_pkg::job_t              push_job, head_job;
  lcc_pkg::div_req_t          div_req;
  logic                       div_done;
  logic [lcc_pkg::GSUM_W-1:0] div_quo;

  lcc_front #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_COLS  (GRID_COLS),
    .PIECE_ROWS (PIECE_ROWS),
    .PIECE_COLS (PIECE_COLS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_cell_symbol (in_cell_symbol),
    .in_place_row   (in_place_row),
    .in_place_col   (in_place_col),
    .in_last        (in_last),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  lcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  lcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  lcc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_job                (head_job),
    .q_pop                (q_pop),
    .div_req              (div_req),
    .div_done             (div_done),
    .div_quo              (div_quo),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_enemy_row_centre (out_enemy_row_centre),
    .out_enemy_col_centre (out_enemy_col_centre),
    .out_own_row_centre   (out_own_row_centre),
    .out_own_col_centre   (out_own_col_centre),
    .out_piece_row_centre (out_piece_row_centre),
    .out_piece_col_centre (out_piece_col_centre),
    .out_dist_own         (out_dist_own),
    .out_dist_enemy       (out_dist_enemy),
    .out_enemy_present    (out_enemy_present),
    .out_own_present      (out_own_present),
    .out_piece_present    (out_piece_present)
  );

endmodule

### sim/tb_labeled_cell_centroid_distance_unit.sv
module tb_labeled_cell_centroid_distance_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_ROWS  = 128;
  localparam int GRID_COLS  = 128;
  localparam int PIECE_ROWS = 32;
  localparam int PIECE_COLS = 32;

  localparam int unsigned GSUM_LIM = (1 << lcc_pkg::GSUM_W) - 1;
  localparam int unsigned GCNT_LIM = (1 << lcc_pkg::GCNT_W) - 1;
  localparam int unsigned PCNT_LIM = (1 << lcc_pkg::PCNT_W) - 1;
  localparam int PSUM_HI = (1 << (lcc_pkg::PSUM_W - 1)) - 1;
  localparam int PSUM_LO = -(1 << (lcc_pkg::PSUM_W - 1));

  // grid results need four serial divisions, so allow well past that
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic                               func;
    logic [lcc_pkg::COORD_W-1:0]        row;
    logic [lcc_pkg::COORD_W-1:0]        col;
    logic [lcc_pkg::SYM_W-1:0]          sym;
    logic signed [lcc_pkg::PLACE_W-1:0] place_row;
    logic signed [lcc_pkg::PLACE_W-1:0] place_col;
    logic                               last;
  } cell_t;

  typedef struct packed {
    logic                              kind;
    logic [lcc_pkg::COORD_W-1:0]       e_row;
    logic [lcc_pkg::COORD_W-1:0]       e_col;
    logic [lcc_pkg::COORD_W-1:0]       o_row;
    logic [lcc_pkg::COORD_W-1:0]       o_col;
    logic signed [lcc_pkg::PCEN_W-1:0] p_row;
    logic signed [lcc_pkg::PCEN_W-1:0] p_col;
    logic [lcc_pkg::DIST_W-1:0]        d_own;
    logic [lcc_pkg::DIST_W-1:0]        d_enemy;
    logic                              e_pres;
    logic                              o_pres;
    logic                              p_pres;
  } centroid_result_t;

  typedef enum int {RCV_OPEN, RCV_COIN, RCV_SLOW, RCV_RARE} stall_mode_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  cell_t drv_cell = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [lcc_pkg::COORD_W-1:0] out_enemy_row_centre, out_enemy_col_centre;
  logic [lcc_pkg::COORD_W-1:0] out_own_row_centre, out_own_col_centre;
  logic signed [lcc_pkg::PCEN_W-1:0] out_piece_row_centre, out_piece_col_centre;
  logic [lcc_pkg::DIST_W-1:0] out_dist_own, out_dist_enemy;
  logic out_enemy_present, out_own_present, out_piece_present;

  labeled_cell_centroid_distance_unit #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .PIECE_ROWS(PIECE_ROWS),
    .PIECE_COLS(PIECE_COLS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (drv_cell.func),
    .in_row              (drv_cell.row),
    .in_col              (drv_cell.col),
    .in_cell_symbol      (drv_cell.sym),
    .in_place_row        (drv_cell.place_row),
    .in_place_col        (drv_cell.place_col),
    .in_last             (drv_cell.last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_enemy_row_centre(out_enemy_row_centre),
    .out_enemy_col_centre(out_enemy_col_centre),
    .out_own_row_centre  (out_own_row_centre),
    .out_own_col_centre  (out_own_col_centre),
    .out_piece_row_centre(out_piece_row_centre),
    .out_piece_col_centre(out_piece_col_centre),
    .out_dist_own        (out_dist_own),
    .out_dist_enemy      (out_dist_enemy),
    .out_enemy_present   (out_enemy_present),
    .out_own_present     (out_own_present),
    .out_piece_present   (out_piece_present)
  );

  cell_t pending_cells[$];
  centroid_result_t expected_results[$];

  // centroid predictor state
  logic [lcc_pkg::SYM_W-1:0] enemy_lbl, own_lbl;
  int unsigned e_rsum, e_csum, e_cnt, o_rsum, o_csum, o_cnt;
  logic [lcc_pkg::COORD_W-1:0] e_row_c, e_col_c, o_row_c, o_col_c;
  logic e_seen, o_seen;
  int p_rsum, p_csum;
  int unsigned p_cnt;

  int mismatch_count;
  int cells_taken, grid_results, piece_results, label_writes;
  logic in_took = 1'b0;
  int burst_left = 1;
  int gap_left;
  cell_t next_cell;
  stall_mode_t rcv_mode = RCV_OPEN;
  int rcv_tick;

  function automatic int unsigned sat_u(int unsigned a, int unsigned b, int unsigned lim);
    int unsigned s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  function automatic int sat_s(int a, int b);
    int s;
    s = a + b;
    if (s > PSUM_HI) return PSUM_HI;
    if (s < PSUM_LO) return PSUM_LO;
    return s;
  endfunction

  function automatic logic [lcc_pkg::COORD_W-1:0] class_centre(int unsigned sum,
                                                               int unsigned cnt);
    int unsigned m;
    if (cnt == 0) return '0;
    m = sum / cnt;
    return (m > 127) ? lcc_pkg::GCEN_MAX : m[lcc_pkg::COORD_W-1:0];
  endfunction

  function automatic int piece_centre(int sum, int unsigned cnt);
    int m;
    if (cnt == 0) return 0;
    m = sum / int'(cnt);  // truncates toward zero
    if (m > 254) m = 254;
    if (m < -128) m = -128;
    return m;
  endfunction

  function automatic logic [lcc_pkg::DIST_W-1:0] sq_dist(int pr, int pc,
                                                         logic [lcc_pkg::COORD_W-1:0] r,
                                                         logic [lcc_pkg::COORD_W-1:0] c);
    int dr, dc, d;
    dr = pr - int'(r);
    dc = pc - int'(c);
    d = dr * dr + dc * dc;
    return d[lcc_pkg::DIST_W-1:0];
  endfunction

  function automatic void step_scan(input cell_t c);
    centroid_result_t r;
    int pr, pc;
    r = '0;
    if (c.func == lcc_pkg::KIND_GRID) begin
      if (c.row < GRID_ROWS && c.col < GRID_COLS) begin
        if (c.sym == enemy_lbl) begin
          e_rsum = sat_u(e_rsum, c.row, GSUM_LIM);
          e_csum = sat_u(e_csum, c.col, GSUM_LIM);
          e_cnt  = sat_u(e_cnt, 1, GCNT_LIM);
        end
        if (c.sym == own_lbl) begin
          o_rsum = sat_u(o_rsum, c.row, GSUM_LIM);
          o_csum = sat_u(o_csum, c.col, GSUM_LIM);
          o_cnt  = sat_u(o_cnt, 1, GCNT_LIM);
        end
      end
      if (!c.last) return;
      e_row_c = class_centre(e_rsum, e_cnt);
      e_col_c = class_centre(e_csum, e_cnt);
      o_row_c = class_centre(o_rsum, o_cnt);
      o_col_c = class_centre(o_csum, o_cnt);
      e_seen = (e_cnt != 0);
      o_seen = (o_cnt != 0);
      e_rsum = 0; e_csum = 0; e_cnt = 0;
      o_rsum = 0; o_csum = 0; o_cnt = 0;
      r.kind = lcc_pkg::KIND_GRID;
    end else begin
      if (c.row < PIECE_ROWS && c.col < PIECE_COLS && c.sym == lcc_pkg::MARK_SYMBOL) begin
        p_rsum = sat_s(p_rsum, int'(c.place_row) + int'(c.row));
        p_csum = sat_s(p_csum, int'(c.place_col) + int'(c.col));
        p_cnt  = sat_u(p_cnt, 1, PCNT_LIM);
      end
      if (!c.last) return;
      pr = piece_centre(p_rsum, p_cnt);
      pc = piece_centre(p_csum, p_cnt);
      r.kind    = lcc_pkg::KIND_PIECE;
      r.p_row   = pr[lcc_pkg::PCEN_W-1:0];
      r.p_col   = pc[lcc_pkg::PCEN_W-1:0];
      r.d_own   = sq_dist(pr, pc, o_row_c, o_col_c);
      r.d_enemy = sq_dist(pr, pc, e_row_c, e_col_c);
      r.p_pres  = (p_cnt != 0);
      p_rsum = 0; p_csum = 0; p_cnt = 0;
    end
    r.e_row  = e_row_c;
    r.e_col  = e_col_c;
    r.o_row  = o_row_c;
    r.o_col  = o_col_c;
    r.e_pres = e_seen;
    r.o_pres = o_seen;
    expected_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result();
    centroid_result_t e;
    if (expected_results.size() == 0) begin
      $error("result beat with no expected result pending");
      mismatch_count++;
      return;
    end
    e = expected_results.pop_front();
    if (e.kind == lcc_pkg::KIND_GRID) grid_results++;
    else piece_results++;
    check_field("kind", e.kind, out_kind);
    check_field("enemy_row_centre", e.e_row, out_enemy_row_centre);
    check_field("enemy_col_centre", e.e_col, out_enemy_col_centre);
    check_field("own_row_centre", e.o_row, out_own_row_centre);
    check_field("own_col_centre", e.o_col, out_own_col_centre);
    check_field("piece_row_centre", e.p_row, out_piece_row_centre);
    check_field("piece_col_centre", e.p_col, out_piece_col_centre);
    check_field("dist_own", e.d_own, out_dist_own);
    check_field("dist_enemy", e.d_enemy, out_dist_enemy);
    check_field("enemy_present", e.e_pres, out_enemy_present);
    check_field("own_present", e.o_pres, out_own_present);
    check_field("piece_present", e.p_pres, out_piece_present);
  endfunction

  function automatic void add_cell(logic func, int row, int col, int sym, int prow,
                                   int pcol, logic last);
    cell_t c;
    c.func      = func;
    c.row       = row[lcc_pkg::COORD_W-1:0];
    c.col       = col[lcc_pkg::COORD_W-1:0];
    c.sym       = sym[lcc_pkg::SYM_W-1:0];
    c.place_row = prow[lcc_pkg::PLACE_W-1:0];
    c.place_col = pcol[lcc_pkg::PLACE_W-1:0];
    c.last      = last;
    pending_cells.push_back(c);
  endfunction

  function automatic cell_t random_cell(logic func);
    cell_t c;
    int pick;
    c.func      = func;
    c.place_row = lcc_pkg::PLACE_W'($urandom);
    c.place_col = lcc_pkg::PLACE_W'($urandom);
    c.last      = 1'b0;
    pick = $urandom_range(0, 99);
    if (func == lcc_pkg::KIND_GRID) begin
      c.row = lcc_pkg::COORD_W'($urandom);
      c.col = lcc_pkg::COORD_W'($urandom);
      c.sym = (pick < 35) ? enemy_lbl : (pick < 70) ? own_lbl : lcc_pkg::SYM_W'($urandom);
    end else begin
      // mostly inside the piece, some beyond its edge
      c.row = ($urandom_range(0, 6) == 0) ? lcc_pkg::COORD_W'($urandom)
                                          : lcc_pkg::COORD_W'($urandom_range(0, 31));
      c.col = ($urandom_range(0, 6) == 0) ? lcc_pkg::COORD_W'($urandom)
                                          : lcc_pkg::COORD_W'($urandom_range(0, 31));
      c.sym = (pick < 70) ? lcc_pkg::MARK_SYMBOL : lcc_pkg::SYM_W'($urandom);
    end
    return c;
  endfunction

  task automatic queue_random_scans(input int budget);
    int left, len, k;
    logic func;
    cell_t c;
    left = budget;
    while (left > 0) begin
      func = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       len = 1;
        7, 8:    len = $urandom_range(21, 60);
        9:       len = $urandom_range(61, 160);
        default: len = $urandom_range(2, 20);
      endcase
      if (len > left) len = left;
      for (k = 0; k < len; k++) begin
        // a stray cell of the other scan type now and then
        if (k < len - 1 && $urandom_range(0, 9) == 0) c = random_cell(!func);
        else c = random_cell(func);
        c.last = (k == len - 1);
        pending_cells.push_back(c);
      end
      left -= len;
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_cells.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_label(input logic [lcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lcc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == lcc_pkg::REG_ENEMY_LABEL) enemy_lbl = val;
    else own_lbl = val;
    label_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_labels(input logic [lcc_pkg::SYM_W-1:0] enemy,
                            input logic [lcc_pkg::SYM_W-1:0] own);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_label(lcc_pkg::REG_ENEMY_LABEL, enemy);
    write_label(lcc_pkg::REG_OWN_LABEL, own);
  endtask

  // half a phase, a full drain with scans possibly left open, then the rest
  task automatic random_phase(input int items);
    queue_random_scans(items / 2);
    wait_idle();
    queue_random_scans(items - items / 2);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  // sender: bursts of beats separated by random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left != 0 || pending_cells.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        next_cell = pending_cells.pop_front();
        drv_cell <= next_cell;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 15) == 0) begin
            burst_left = 200;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall pattern re-picked at random from the four modes
  always @(negedge clk) begin
    rcv_tick++;
    if (rcv_tick % 48 == 0) rcv_mode = stall_mode_t'($urandom_range(0, 3));
    case (rcv_mode)
      RCV_OPEN: out_ready <= 1'b1;
      RCV_COIN: out_ready <= 1'($urandom_range(0, 1));
      RCV_SLOW: out_ready <= (rcv_tick % 7) < 2;
      default:  out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        cells_taken++;
        step_scan(drv_cell);
      end
      if (out_valid && out_ready) check_result();
    end
  end

  initial begin
    enemy_lbl = lcc_pkg::ENEMY_LABEL_RST;
    own_lbl   = lcc_pkg::OWN_LABEL_RST;
    e_rsum = 0; e_csum = 0; e_cnt = 0;
    o_rsum = 0; o_csum = 0; o_cnt = 0;
    e_row_c = '0; e_col_c = '0; o_row_c = '0; o_col_c = '0;
    e_seen = 1'b0; o_seen = 1'b0;
    p_rsum = 0; p_csum = 0; p_cnt = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // piece before any grid: centres read as zero, out-of-piece cells dropped
    add_cell(lcc_pkg::KIND_PIECE, 0, 0, lcc_pkg::MARK_SYMBOL, -128, -128, 1'b0);
    add_cell(lcc_pkg::KIND_PIECE, 31, 31, lcc_pkg::MARK_SYMBOL, 127, 127, 1'b0);
    add_cell(lcc_pkg::KIND_PIECE, 32, 3, lcc_pkg::MARK_SYMBOL, 5, 5, 1'b0);
    add_cell(lcc_pkg::KIND_PIECE, 3, 127, lcc_pkg::MARK_SYMBOL, 5, 5, 1'b0);
    add_cell(lcc_pkg::KIND_PIECE, 4, 4, 8'h41, 0, 0, 1'b1);
    add_cell(lcc_pkg::KIND_PIECE, 0, 0, 8'h00, 0, 0, 1'b1);
    // grid corners for both classes
    add_cell(lcc_pkg::KIND_GRID, 0, 0, lcc_pkg::ENEMY_LABEL_RST, -1, -1, 1'b0);
    add_cell(lcc_pkg::KIND_GRID, 127, 127, lcc_pkg::ENEMY_LABEL_RST, 0, 0, 1'b0);
    add_cell(lcc_pkg::KIND_GRID, 127, 0, lcc_pkg::OWN_LABEL_RST, 0, 0, 1'b0);
    add_cell(lcc_pkg::KIND_GRID, 0, 127, lcc_pkg::OWN_LABEL_RST, 127, -128, 1'b0);
    add_cell(lcc_pkg::KIND_GRID, 64, 64, 8'hFF, 0, 0, 1'b0);
    add_cell(lcc_pkg::KIND_GRID, 127, 127, lcc_pkg::OWN_LABEL_RST, 0, 0, 1'b1);
    // negative piece centre, then the far corner
    add_cell(lcc_pkg::KIND_PIECE, 0, 0, lcc_pkg::MARK_SYMBOL, -128, -100, 1'b0);
    add_cell(lcc_pkg::KIND_PIECE, 1, 2, lcc_pkg::MARK_SYMBOL, -128, -100, 1'b1);
    add_cell(lcc_pkg::KIND_PIECE, 31, 31, lcc_pkg::MARK_SYMBOL, 127, 127, 1'b1);
    // empty grid classes, then distances from zero centres
    add_cell(lcc_pkg::KIND_GRID, 5, 5, 8'h00, 0, 0, 1'b1);
    add_cell(lcc_pkg::KIND_PIECE, 10, 10, lcc_pkg::MARK_SYMBOL, 0, 0, 1'b1);

    // same label on both classes
    set_labels(8'hFF, 8'hFF);
    add_cell(lcc_pkg::KIND_GRID, 1, 2, 8'hFF, 0, 0, 1'b0);
    add_cell(lcc_pkg::KIND_GRID, 3, 4, 8'hFF, 0, 0, 1'b1);

    set_labels(8'h00, lcc_pkg::MARK_SYMBOL);
    add_cell(lcc_pkg::KIND_GRID, 7, 9, 8'h00, 0, 0, 1'b1);
    add_cell(lcc_pkg::KIND_PIECE, 0, 0, lcc_pkg::MARK_SYMBOL, 0, 0, 1'b1);

    set_labels(8'h00, 8'hFF);
    random_phase(390);
    set_labels(8'hFF, 8'h00);
    random_phase(390);
    set_labels(lcc_pkg::ENEMY_LABEL_RST, lcc_pkg::OWN_LABEL_RST);
    random_phase(390);
    set_labels(lcc_pkg::SYM_W'($urandom), 8'h00);
    write_label(lcc_pkg::REG_OWN_LABEL, enemy_lbl);
    random_phase(390);
    set_labels(lcc_pkg::SYM_W'($urandom), lcc_pkg::SYM_W'($urandom));
    random_phase(370);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d cells and %0d results (%0d grid, %0d piece) over %0d label writes",
             cells_taken, grid_results + piece_results, grid_results, piece_results,
             label_writes);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
